[rtl/core/fqws_pkg.sv]
// ----------------------------------------------------------------------------
// fqws_pkg
// Shared types and constants for the FIFO queue with sort unit.
// ----------------------------------------------------------------------------
package fqws_pkg;

    parameter int DEPTH_DEFAULT     = 32;
    parameter int WORD_BITS_DEFAULT = 32;

    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 6;
    localparam int OP_BITS    = 2;
    localparam int S_DATA_BITS = 32;
    localparam int M_DATA_BITS = 40;
    localparam int M_USER_BITS = 2;

    localparam logic [VALUE_BITS-1:0] EMPTY_WORD = '1;

    typedef enum logic [OP_BITS-1:0] {
        OP_ENQ   = 2'd0,
        OP_DEQ   = 2'd1,
        OP_SORT  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEQ,
        ST_SORT_LOAD,
        ST_SORT_CMP,
        ST_SORT_PUT
    } state_t;

endpackage

[rtl/core/fqws_ram.sv]
// ----------------------------------------------------------------------------
// fqws_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fqws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/fifo_queue_with_sort_unit.sv]
// ----------------------------------------------------------------------------
// fifo_queue_with_sort_unit
// Bounded ring-buffer FIFO of signed words with in-place stable insertion sort.
// ----------------------------------------------------------------------------
// One operation per input word, one result word per operation. Enqueue, clear,
// dequeue on an empty queue and sort of fewer than two entries finish in the
// accept cycle; dequeue of a non-empty queue passes through a read state for
// the registered RAM read. Sort of n entries walks the ring with one RAM read
// port and one signed comparator: per entry i it runs a load step, a compare
// step per entry shifted, and a closing step (the compare that stops the shift,
// or a put step when the entry moves to the head). The input is not ready while
// an operation is in progress or while a result waits unclaimed on the output.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module fifo_queue_with_sort_unit #(
    parameter int DEPTH     = fqws_pkg::DEPTH_DEFAULT,
    parameter int WORD_BITS = fqws_pkg::WORD_BITS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [fqws_pkg::S_DATA_BITS-1:0]     s_tdata,  // [31:0] value
    input  logic [fqws_pkg::OP_BITS-1:0]         s_tuser,  // [1:0] operation
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [fqws_pkg::M_DATA_BITS-1:0]     m_tdata,  // [31:0] head_value,
                                                           // [37:32] entry_count
    output logic [fqws_pkg::M_USER_BITS-1:0]     m_tuser   // [0] was_empty,
                                                           // [1] dropped
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int VB = fqws_pkg::VALUE_BITS;
    localparam int NB = fqws_pkg::COUNT_BITS;

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
        ring_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] p);
        ring_dec = (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
    endfunction

    fqws_pkg::state_t state_reg, state_next;

    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        i_reg, i_next;
    logic [AW-1:0]        pi_reg, pi_next;
    logic [AW-1:0]        j_reg, j_next;
    logic [AW-1:0]        pj_reg, pj_next;
    logic [AW-1:0]        pjm_reg, pjm_next;
    logic [WORD_BITS-1:0] t_reg, t_next;

    logic                 m_valid_reg, m_valid_next;
    logic [VB-1:0]        head_value_reg, head_value_next;
    logic                 was_empty_reg, was_empty_next;
    logic                 dropped_reg, dropped_next;
    logic [NB-1:0]        entry_count_reg, entry_count_next;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [WORD_BITS-1:0]        ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic signed [WORD_BITS-1:0] ram_rdata;

    logic                  s_acc;
    fqws_pkg::op_t         op;
    logic signed [VB-1:0]  s_value;
    logic [AW:0]           tail_sum;
    logic [AW-1:0]         tail_addr;
    logic                  is_full;
    logic                  is_empty;
    logic                  few_entries;
    logic                  cmp_less;
    logic                  sort_last;
    logic                  j_last;

    assign op       = fqws_pkg::op_t'(s_tuser);
    assign s_value  = s_tdata[VB-1:0];
    assign s_tready = (state_reg == fqws_pkg::ST_IDLE) && (!m_valid_reg || m_tready);
    assign s_acc    = s_tvalid && s_tready;

    assign tail_sum    = (AW+1)'(head_reg) + (AW+1)'(count_reg);
    assign tail_addr   = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                      : AW'(tail_sum);
    assign is_full     = (count_reg == CW'(DEPTH));
    assign is_empty    = (count_reg == '0);
    assign few_entries = (count_reg < CW'(2));
    assign cmp_less    = $signed(t_reg) < ram_rdata;
    assign sort_last   = ((CW'(i_reg) + CW'(1)) == count_reg);
    assign j_last      = (j_reg == AW'(1));

    fqws_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fqws_pkg::ST_IDLE: begin
                if (s_acc) begin
                    if (op == fqws_pkg::OP_DEQ && !is_empty) begin
                        state_next = fqws_pkg::ST_DEQ;
                    end else if (op == fqws_pkg::OP_SORT && !few_entries) begin
                        state_next = fqws_pkg::ST_SORT_LOAD;
                    end
                end
            end
            fqws_pkg::ST_DEQ: begin
                state_next = fqws_pkg::ST_IDLE;
            end
            fqws_pkg::ST_SORT_LOAD: begin
                state_next = fqws_pkg::ST_SORT_CMP;
            end
            fqws_pkg::ST_SORT_CMP: begin
                if (cmp_less) begin
                    state_next = j_last ? fqws_pkg::ST_SORT_PUT : fqws_pkg::ST_SORT_CMP;
                end else begin
                    state_next = sort_last ? fqws_pkg::ST_IDLE : fqws_pkg::ST_SORT_LOAD;
                end
            end
            fqws_pkg::ST_SORT_PUT: begin
                state_next = sort_last ? fqws_pkg::ST_IDLE : fqws_pkg::ST_SORT_LOAD;
            end
            default: begin
                state_next = fqws_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        head_next        = head_reg;
        count_next       = count_reg;
        i_next           = i_reg;
        pi_next          = pi_reg;
        j_next           = j_reg;
        pj_next          = pj_reg;
        pjm_next         = pjm_reg;
        t_next           = t_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        head_value_next  = head_value_reg;
        was_empty_next   = was_empty_reg;
        dropped_next     = dropped_reg;
        entry_count_next = entry_count_reg;
        ram_we           = 1'b0;
        ram_waddr        = pj_reg;
        ram_wdata        = t_reg;
        ram_raddr        = head_reg;

        unique case (state_reg)
            fqws_pkg::ST_IDLE: begin
                if (s_acc) begin
                    head_value_next = '0;
                    was_empty_next  = 1'b0;
                    dropped_next    = 1'b0;
                    unique case (op)
                        fqws_pkg::OP_ENQ: begin
                            if (is_full) begin
                                dropped_next = 1'b1;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = tail_addr;
                                ram_wdata  = WORD_BITS'(s_value);
                                count_next = count_reg + 1'b1;
                            end
                            m_valid_next     = 1'b1;
                            entry_count_next = NB'(count_next);
                        end
                        fqws_pkg::OP_DEQ: begin
                            if (is_empty) begin
                                head_value_next  = fqws_pkg::EMPTY_WORD;
                                was_empty_next   = 1'b1;
                                m_valid_next     = 1'b1;
                                entry_count_next = NB'(count_reg);
                            end else begin
                                ram_raddr  = head_reg;
                                head_next  = ring_inc(head_reg);
                                count_next = count_reg - 1'b1;
                            end
                        end
                        fqws_pkg::OP_SORT: begin
                            if (few_entries) begin
                                m_valid_next     = 1'b1;
                                entry_count_next = NB'(count_reg);
                            end else begin
                                i_next    = AW'(1);
                                pi_next   = ring_inc(head_reg);
                                ram_raddr = ring_inc(head_reg);
                            end
                        end
                        fqws_pkg::OP_CLEAR: begin
                            head_next        = '0;
                            count_next       = '0;
                            m_valid_next     = 1'b1;
                            entry_count_next = '0;
                        end
                        default: begin
                            m_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            fqws_pkg::ST_DEQ: begin
                head_value_next  = VB'(ram_rdata);
                m_valid_next     = 1'b1;
                entry_count_next = NB'(count_reg);
            end
            fqws_pkg::ST_SORT_LOAD: begin
                t_next    = ram_rdata;
                j_next    = i_reg;
                pj_next   = pi_reg;
                pjm_next  = ring_dec(pi_reg);
                ram_raddr = ring_dec(pi_reg);
            end
            fqws_pkg::ST_SORT_CMP: begin
                ram_we    = 1'b1;
                ram_waddr = pj_reg;
                if (cmp_less) begin
                    ram_wdata = ram_rdata;
                    j_next    = j_reg - 1'b1;
                    pj_next   = pjm_reg;
                    pjm_next  = ring_dec(pjm_reg);
                    ram_raddr = ring_dec(pjm_reg);
                end else begin
                    ram_wdata = t_reg;
                    i_next    = i_reg + 1'b1;
                    pi_next   = ring_inc(pi_reg);
                    ram_raddr = ring_inc(pi_reg);
                    if (sort_last) begin
                        m_valid_next     = 1'b1;
                        entry_count_next = NB'(count_reg);
                    end
                end
            end
            fqws_pkg::ST_SORT_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = pj_reg;
                ram_wdata = t_reg;
                i_next    = i_reg + 1'b1;
                pi_next   = ring_inc(pi_reg);
                ram_raddr = ring_inc(pi_reg);
                if (sort_last) begin
                    m_valid_next     = 1'b1;
                    entry_count_next = NB'(count_reg);
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fqws_pkg::ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg           <= i_next;
        pi_reg          <= pi_next;
        j_reg           <= j_next;
        pj_reg          <= pj_next;
        pjm_reg         <= pjm_next;
        t_reg           <= t_next;
        head_value_reg  <= head_value_next;
        was_empty_reg   <= was_empty_next;
        dropped_reg     <= dropped_next;
        entry_count_reg <= entry_count_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(fqws_pkg::M_DATA_BITS - VB - NB)'(0), entry_count_reg, head_value_reg};
    assign m_tuser  = {dropped_reg, was_empty_reg};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (state_reg == fqws_pkg::ST_IDLE))
        else $error("input ready while busy");

    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(was_empty_reg && dropped_reg))
        else $error("empty and drop flags both set");

    a_deq_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tuser == fqws_pkg::OP_DEQ && count_reg != '0)
        |=> (state_reg == fqws_pkg::ST_DEQ && !m_valid_reg))
        else $error("dequeue did not wait for read data");
`endif

endmodule

[dv/fifo_queue_with_sort_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_sort_unit_tb
// Self-checking bench for the bounded FIFO with in-place insertion sort.
// ----------------------------------------------------------------------------
// A short table of directed words covers empty and single-entry cases, the
// value extremes and every operation. Random sequences then fill the queue
// past full, drain it past empty, sort across the ring wrap and clear it.
// Every result word is checked field by field against the table for typed
// rows and otherwise against a behavioral queue kept in the bench. Both stream
// sides idle at random; the receiver also holds off once for a long stretch.
// ----------------------------------------------------------------------------
module fifo_queue_with_sort_unit_tb;

    localparam int QDEPTH       = fqws_pkg::DEPTH_DEFAULT;
    localparam int QWORD_BITS   = fqws_pkg::WORD_BITS_DEFAULT;
    localparam int VBITS        = fqws_pkg::VALUE_BITS;
    localparam int RANDOM_ITEMS = 750;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int REPORT_LIMIT = 60;

    typedef struct packed {
        logic [VBITS-1:0]                head_value;
        logic                            was_empty;
        logic                            dropped;
        logic [fqws_pkg::COUNT_BITS-1:0] entry_count;
    } queue_result_t;

    typedef struct packed {
        fqws_pkg::op_t    op;
        logic [VBITS-1:0] value;
        logic             typed;
        queue_result_t    result;
    } directed_row_t;

    localparam queue_result_t NO_RESULT = '0;
    localparam logic [VBITS-1:0] EMPTY_RES = fqws_pkg::EMPTY_WORD;

    localparam directed_row_t DIRECTED_ROWS [23] = '{
        '{fqws_pkg::OP_DEQ,   32'h0000_0000, 1'b1, '{EMPTY_RES, 1'b1, 1'b0, 6'd0}},
        '{fqws_pkg::OP_SORT,  32'h0000_0000, 1'b1, '{32'h0, 1'b0, 1'b0, 6'd0}},
        '{fqws_pkg::OP_CLEAR, 32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, 1'b0, 6'd0}},
        '{fqws_pkg::OP_ENQ,   32'h7FFF_FFFF, 1'b1, '{32'h0, 1'b0, 1'b0, 6'd1}},
        '{fqws_pkg::OP_SORT,  32'h1234_5678, 1'b1, '{32'h0, 1'b0, 1'b0, 6'd1}},
        '{fqws_pkg::OP_ENQ,   32'h8000_0000, 1'b1, '{32'h0, 1'b0, 1'b0, 6'd2}},
        '{fqws_pkg::OP_ENQ,   32'h0000_0000, 1'b1, '{32'h0, 1'b0, 1'b0, 6'd3}},
        '{fqws_pkg::OP_ENQ,   32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, 1'b0, 6'd4}},
        '{fqws_pkg::OP_ENQ,   32'h0000_0001, 1'b0, NO_RESULT},
        '{fqws_pkg::OP_ENQ,   32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{fqws_pkg::OP_SORT,  32'h0000_0000, 1'b0, NO_RESULT},
        '{fqws_pkg::OP_DEQ,   32'h0000_0000, 1'b1, '{32'h8000_0000, 1'b0, 1'b0, 6'd5}},
        '{fqws_pkg::OP_DEQ,   32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{fqws_pkg::OP_DEQ,   32'h0000_0000, 1'b0, NO_RESULT},
        '{fqws_pkg::OP_CLEAR, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, 1'b0, 6'd0}},
        '{fqws_pkg::OP_DEQ,   32'h0000_0000, 1'b1, '{EMPTY_RES, 1'b1, 1'b0, 6'd0}},
        '{fqws_pkg::OP_ENQ,   32'h5555_5555, 1'b0, NO_RESULT},
        '{fqws_pkg::OP_ENQ,   32'hAAAA_AAAA, 1'b0, NO_RESULT},
        '{fqws_pkg::OP_SORT,  32'hAAAA_AAAA, 1'b0, NO_RESULT},
        '{fqws_pkg::OP_DEQ,   32'h0000_0000, 1'b1, '{32'hAAAA_AAAA, 1'b0, 1'b0, 6'd1}},
        '{fqws_pkg::OP_DEQ,   32'h0000_0000, 1'b1, '{32'h5555_5555, 1'b0, 1'b0, 6'd0}},
        '{fqws_pkg::OP_DEQ,   32'h0000_0000, 1'b1, '{EMPTY_RES, 1'b1, 1'b0, 6'd0}},
        '{fqws_pkg::OP_ENQ,   32'h0000_0005, 1'b1, '{32'h0, 1'b0, 1'b0, 6'd1}}
    };

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [fqws_pkg::S_DATA_BITS-1:0] s_tdata;
    logic [fqws_pkg::OP_BITS-1:0]     s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [fqws_pkg::M_DATA_BITS-1:0] m_tdata;
    logic [fqws_pkg::M_USER_BITS-1:0] m_tuser;

    logic signed [QWORD_BITS-1:0] queue_words [QDEPTH];
    int                           queue_head;
    int                           queue_count;

    queue_result_t awaited_results [$];
    int            error_count = 0;
    int            cycle_count = 0;
    int            words_sent  = 0;
    bit            no_idle     = 1'b0;
    bit            long_hold_req = 1'b0;

    always #5 aclk = ~aclk;

    fifo_queue_with_sort_unit #(
        .DEPTH     (QDEPTH),
        .WORD_BITS (QWORD_BITS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    function automatic queue_result_t queue_op_result(fqws_pkg::op_t op,
                                                      logic [VBITS-1:0] value);
        queue_result_t                res;
        logic signed [QWORD_BITS-1:0] sorted_words [QDEPTH];
        logic signed [QWORD_BITS-1:0] held;
        int                           i;
        int                           j;
        res = '0;
        case (op)
            fqws_pkg::OP_ENQ: begin
                if (queue_count >= QDEPTH) begin
                    res.dropped = 1'b1;
                end else begin
                    queue_words[(queue_head + queue_count) % QDEPTH] = QWORD_BITS'($signed(value));
                    queue_count++;
                end
            end
            fqws_pkg::OP_DEQ: begin
                if (queue_count == 0) begin
                    res.head_value = EMPTY_RES;
                    res.was_empty  = 1'b1;
                end else begin
                    res.head_value = VBITS'(queue_words[queue_head]);
                    queue_head = (queue_head + 1) % QDEPTH;
                    queue_count--;
                end
            end
            fqws_pkg::OP_SORT: begin
                for (i = 0; i < queue_count; i++)
                    sorted_words[i] = queue_words[(queue_head + i) % QDEPTH];
                for (i = 1; i < queue_count; i++) begin
                    held = sorted_words[i];
                    j = i;
                    while (j > 0 && held < sorted_words[j-1]) begin
                        sorted_words[j] = sorted_words[j-1];
                        j--;
                    end
                    sorted_words[j] = held;
                end
                for (i = 0; i < queue_count; i++)
                    queue_words[(queue_head + i) % QDEPTH] = sorted_words[i];
            end
            default: begin
                queue_count = 0;
                queue_head  = 0;
            end
        endcase
        res.entry_count = fqws_pkg::COUNT_BITS'(queue_count);
        return res;
    endfunction

    function automatic int idle_draw();
        return no_idle ? 0 : int'($urandom_range(0, 9));
    endfunction

    function automatic logic [VBITS-1:0] random_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return $urandom;
        else if (pick < 80)
            return VBITS'($signed($urandom_range(0, 8)) - 4);
        else
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
    endfunction

    function automatic fqws_pkg::op_t random_op();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return fqws_pkg::OP_ENQ;
        else if (pick < 85)
            return fqws_pkg::OP_DEQ;
        else if (pick < 93)
            return fqws_pkg::OP_SORT;
        else
            return fqws_pkg::OP_CLEAR;
    endfunction

    task automatic send_word(fqws_pkg::op_t op, logic [VBITS-1:0] value, logic typed,
                             queue_result_t typed_result);
        int            gap;
        queue_result_t predicted;
        gap = idle_draw();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        predicted = queue_op_result(op, value);
        awaited_results.push_back(typed ? typed_result : predicted);
        words_sent++;
    endtask

    // sender
    initial begin
        int  target;
        int  k;
        bit  hold_done;
        bit  pause_done;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = fqws_pkg::OP_ENQ;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        queue_head  = 0;
        queue_count = 0;
        for (k = 0; k < QDEPTH; k++)
            queue_words[k] = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED_ROWS[r])
            send_word(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].typed,
                      DIRECTED_ROWS[r].result);

        target = words_sent + RANDOM_ITEMS;
        while (words_sent < target) begin
            no_idle = ($urandom_range(0, 3) == 0);
            if (!hold_done && words_sent >= 200) begin
                long_hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && words_sent >= 450) begin
                s_tvalid <= 1'b0;
                while (awaited_results.size() != 0) @(posedge aclk);
                @(posedge aclk);
                pause_done = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    // fill, often past full
                    repeat ($urandom_range(1, 40))
                        send_word(fqws_pkg::OP_ENQ, random_value(), 1'b0, NO_RESULT);
                end
                3, 4: begin
                    // drain, often past empty
                    repeat ($urandom_range(1, 36))
                        send_word(fqws_pkg::OP_DEQ, random_value(), 1'b0, NO_RESULT);
                end
                5, 6: begin
                    repeat ($urandom_range(0, 12))
                        send_word(fqws_pkg::OP_ENQ, random_value(), 1'b0, NO_RESULT);
                    send_word(fqws_pkg::OP_SORT, random_value(), 1'b0, NO_RESULT);
                    repeat ($urandom_range(0, 12))
                        send_word(fqws_pkg::OP_DEQ, random_value(), 1'b0, NO_RESULT);
                end
                7, 8: begin
                    repeat (10)
                        send_word(random_op(), random_value(), 1'b0, NO_RESULT);
                end
                default: begin
                    send_word(fqws_pkg::OP_CLEAR, random_value(), 1'b0, NO_RESULT);
                end
            endcase
        end

        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver
    initial begin
        int stall;
        m_tready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            stall = idle_draw();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    always @(posedge aclk) begin
        queue_result_t seen;
        queue_result_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            seen = '{m_tdata[31:0], m_tuser[0], m_tuser[1], m_tdata[37:32]};
            if (awaited_results.size() == 0) begin
                error_count++;
                if (error_count < REPORT_LIMIT)
                    $display("%0t: unexpected result word %h", $time, seen);
            end else begin
                want = awaited_results.pop_front();
                if (seen.head_value !== want.head_value) begin
                    error_count++;
                    if (error_count < REPORT_LIMIT)
                        $display("%0t: head_value expected %h actual %h",
                                 $time, want.head_value, seen.head_value);
                end
                if (seen.was_empty !== want.was_empty) begin
                    error_count++;
                    if (error_count < REPORT_LIMIT)
                        $display("%0t: was_empty expected %b actual %b",
                                 $time, want.was_empty, seen.was_empty);
                end
                if (seen.dropped !== want.dropped) begin
                    error_count++;
                    if (error_count < REPORT_LIMIT)
                        $display("%0t: dropped expected %b actual %b",
                                 $time, want.dropped, seen.dropped);
                end
                if (seen.entry_count !== want.entry_count) begin
                    error_count++;
                    if (error_count < REPORT_LIMIT)
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, want.entry_count, seen.entry_count);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
